[src/rrc_pkg.sv]
// Package for the rectangle raster canvas: sizes, codes, command and status types.
// Used by every other file of the block; depends on nothing.
`default_nettype none

package rrc_pkg;

  // Canvas geometry
  localparam int MAX_SIDE  = 256;
  localparam int IDX_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int ADDR_W    = 2 * IDX_W;

  // Fixed point coordinates
  localparam int FRAC_BITS = 8;
  localparam int FIELD_W   = 20;
  localparam int PIX_W     = IDX_W + FRAC_BITS;
  localparam int COORD_W   = ((FIELD_W > PIX_W) ? FIELD_W : PIX_W) + 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'((1 << (FIELD_W - 1)) - 1);
  localparam coord_t ONE       = coord_t'(1 << FRAC_BITS);

  // Payload widths
  localparam int CHAR_W     = 8;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_SIZE_W = 9;
  localparam int CFG_DATA_W = CFG_SIZE_W;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_DRAW  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_READ  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(2);

  // Rectangle kinds ('R' and 'r')
  localparam logic [CHAR_W-1:0] KIND_FILLED  = 8'h52;
  localparam logic [CHAR_W-1:0] KIND_OUTLINE = 8'h72;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_CHAR = CFG_IDX_W'(2);

  // Reset values of the configuration registers
  localparam logic [CFG_SIZE_W-1:0] RST_CANVAS_SIDE = CFG_SIZE_W'(256);
  localparam logic [CHAR_W-1:0]     RST_BACKGROUND  = CHAR_W'(32);

  // Command queue between front and back
  localparam int Q_PTR_W = 1;
  localparam int Q_DEPTH = 1 << Q_PTR_W;

  typedef enum logic [2:0] {
    OP_FILL,
    OP_OUTLINE,
    OP_READ,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t                 op;
    coord_t              left;
    coord_t              top;
    coord_t              right;
    coord_t              bottom;
    logic [CHAR_W-1:0]   paint;
    logic [ADDR_W-1:0]   addr;
  } cmd_t;

  // Effective (clamped) canvas configuration
  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [CHAR_W-1:0] bg;
  } canvas_cfg_t;

  // Back-end status seen by the top level
  typedef struct packed {
    logic idle;
    logic walking;
    logic pop;
  } back_stat_t;

  // Size register value 0 acts as 1, values above MAX_SIDE act as MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIZE_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      return SIDE_W'(1);
    end else if (w > 32'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return SIDE_W'(w);
    end
  endfunction

endpackage

`default_nettype wire

[src/rrc_if.sv]
// Request and result channel interfaces of the rectangle raster canvas.
// Depends on rrc_pkg for field widths.
`default_nettype none

interface rrc_req_if import rrc_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [CHAR_W-1:0]         rect_kind;
  logic signed [FIELD_W-1:0] rect_left;
  logic signed [FIELD_W-1:0] rect_top;
  logic signed [FIELD_W-1:0] rect_width;
  logic signed [FIELD_W-1:0] rect_height;
  logic [CHAR_W-1:0]         paint_char;
  logic [IDX_W-1:0]          pixel_col;
  logic [IDX_W-1:0]          pixel_row;

  modport source (
    output valid, mode, rect_kind, rect_left, rect_top, rect_width, rect_height,
           paint_char, pixel_col, pixel_row,
    input  ready
  );

  modport sink (
    input  valid, mode, rect_kind, rect_left, rect_top, rect_width, rect_height,
           paint_char, pixel_col, pixel_row,
    output ready
  );
endinterface

interface rrc_rsp_if import rrc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] pixel_value;
  logic              status;

  modport source (output valid, pixel_value, status, input ready);
  modport sink   (input valid, pixel_value, status, output ready);
endinterface

`default_nettype wire

[src/rrc_front.sv]
// Front end: accepts requests, validates them and turns them into queue commands.
// Depends on rrc_pkg and rrc_req_if.
`default_nettype none

module rrc_front import rrc_pkg::*; (
  rrc_req_if.sink           req,
  input  canvas_cfg_t       cfg,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              cmd
);

  coord_t left, top, width, height;
  coord_t right_raw, bottom_raw;
  logic   kind_ok, size_ok, read_ok;

  // Take a request whenever the queue has room
  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

  // Edges, unsaturated right and bottom edges
  always_comb begin
    left       = coord_t'(req.rect_left);
    top        = coord_t'(req.rect_top);
    width      = coord_t'(req.rect_width);
    height     = coord_t'(req.rect_height);
    right_raw  = left + width;
    bottom_raw = top + height;
  end

  assign kind_ok = (req.rect_kind == KIND_FILLED) || (req.rect_kind == KIND_OUTLINE);
  assign size_ok = (width > coord_t'(0)) && (height > coord_t'(0));
  assign read_ok = (SIDE_W'(req.pixel_col) < cfg.width) &&
                   (SIDE_W'(req.pixel_row) < cfg.height);

  // Classify
  always_comb begin
    cmd.left   = left;
    cmd.top    = top;
    cmd.right  = (right_raw > COORD_MAX) ? COORD_MAX : right_raw;
    cmd.bottom = (bottom_raw > COORD_MAX) ? COORD_MAX : bottom_raw;
    cmd.paint  = req.paint_char;
    cmd.addr   = {req.pixel_row, req.pixel_col};
    unique case (req.mode)
      MODE_DRAW: begin
        if (!kind_ok || !size_ok) begin
          cmd.op = OP_REJECT;
        end else if (req.rect_kind == KIND_FILLED) begin
          cmd.op = OP_FILL;
        end else begin
          cmd.op = OP_OUTLINE;
        end
      end
      MODE_READ:  cmd.op = read_ok ? OP_READ : OP_REJECT;
      MODE_CLEAR: cmd.op = OP_CLEAR;
      default:    cmd.op = OP_REJECT;
    endcase
  end

endmodule

`default_nettype wire

[src/rrc_cmd_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on rrc_pkg for cmd_t and the queue depth.
`default_nettype none

module rrc_cmd_queue import rrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t cmd_in,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_PTR_W:0]    count;

  assign full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

[src/rrc_back.sv]
// Back end: canvas memory, pixel walker for draw and clear, reads and the result register.
// Depends on rrc_pkg and rrc_rsp_if.
`default_nettype none

module rrc_back import rrc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  canvas_cfg_t  cfg,
  input  logic         q_empty,
  input  cmd_t         head,
  output logic         q_pop,
  rrc_rsp_if.source    rsp,
  output back_stat_t   stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_READ
  } state_t;

  state_t             state;
  cmd_t               cur;
  logic [IDX_W-1:0]   row, col;
  logic [IDX_W-1:0]   lim_row, lim_col;
  logic               out_valid;
  logic [CHAR_W-1:0]  out_value;
  logic               out_status;

  logic [CHAR_W-1:0]  mem [MAX_SIDE * MAX_SIDE];
  logic [CHAR_W-1:0]  rd_data;

  coord_t             px, py;
  logic               col_in, row_in, on_edge, is_clear, last;
  logic               mem_we;
  logic [CHAR_W-1:0]  mem_wdata;
  logic               slot_free;
  logic               res_load;

  // Output slot is free when empty or being taken now
  assign slot_free = !out_valid || rsp.ready;
  assign q_pop     = (state == ST_IDLE) && !q_empty && slot_free;

  // A result enters the output register: reject, end of walk, or read data
  assign res_load = ((state == ST_IDLE) && q_pop && (head.op == OP_REJECT)) ||
                    ((state == ST_WALK) && last) ||
                    (state == ST_READ);

  // Pixel test for the current walk position
  always_comb begin
    px       = coord_t'(col) << FRAC_BITS;
    py       = coord_t'(row) << FRAC_BITS;
    col_in   = (px >= cur.left) && (px <= cur.right);
    row_in   = (py >= cur.top) && (py <= cur.bottom);
    on_edge  = ((cur.right - px) < ONE) || ((cur.bottom - py) < ONE) ||
               ((px - cur.left) < ONE) || ((py - cur.top) < ONE);
    is_clear = (cur.op == OP_CLEAR);
    last     = (col == lim_col) && (row == lim_row);
    mem_we   = (state == ST_WALK) &&
               (is_clear || (col_in && row_in && ((cur.op == OP_FILL) || on_edge)));
    mem_wdata = is_clear ? cfg.bg : cur.paint;
  end

  // Canvas memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{row, col}] <= mem_wdata;
    end
    rd_data <= mem[head.addr];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur <= head;
            row <= '0;
            col <= '0;
            if (head.op == OP_CLEAR) begin
              lim_col <= '1;
              lim_row <= '1;
            end else begin
              lim_col <= IDX_W'(cfg.width - SIDE_W'(1));
              lim_row <= IDX_W'(cfg.height - SIDE_W'(1));
            end
            unique case (head.op)
              OP_FILL, OP_OUTLINE, OP_CLEAR: state <= ST_WALK;
              OP_READ:                       state <= ST_READ;
              OP_REJECT: begin
                out_value  <= '0;
                out_status <= 1'b1;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (col == lim_col) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          if (last) begin
            state      <= ST_IDLE;
            out_value  <= '0;
            out_status <= 1'b0;
          end
        end
        ST_READ: begin
          state      <= ST_IDLE;
          out_value  <= rd_data;
          out_status <= 1'b0;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pixel_value = out_value;
  assign rsp.status      = out_status;

  assign stat.idle    = (state == ST_IDLE);
  assign stat.walking = (state == ST_WALK);
  assign stat.pop     = q_pop;

endmodule

`default_nettype wire

[src/rectangle_raster_canvas_unit.sv]
// Rectangle raster canvas, top level: config registers, front end, queue, back end.
// Depends on rrc_pkg, rrc_if, rrc_front, rrc_cmd_queue and rrc_back.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves on
// rsp (valid/ready), in request order. Config is written through cfg_we,
// cfg_index and cfg_data while the block is idle: 0 canvas_width, 1 canvas_height,
// 2 background_char; other indexes are ignored.
// Steps per request, once the back end takes it from the queue:
//   rejected or mode 3: result loaded as the back end takes it
//   read:               canvas data register, then the result register
//   draw:               canvas_width x canvas_height pixels walked (sizes in use), then the result
//   clear:              whole 256 x 256 store walked, then the result
// Draw and clear visit one pixel per cycle through the single canvas write port.
// A request accepted into an empty queue is taken by the back end in the next cycle when the
// back end is idle and its output register is free. Reset: sizes 256 x 256, background 32,
// queue empty, no result pending; the canvas contents are undefined until a clear or draw writes them.
// When rsp stalls, the result stays in the output register, the back end waits
// before starting the next request, and req.ready drops once the two-entry queue
// is full.
`default_nettype none

module rectangle_raster_canvas_unit import rrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rrc_req_if.sink               req,
  rrc_rsp_if.source             rsp
);

  logic [CFG_SIZE_W-1:0] canvas_width;
  logic [CFG_SIZE_W-1:0] canvas_height;
  logic [CHAR_W-1:0]     background_char;
  canvas_cfg_t           cfg_eff;

  logic       q_push, q_pop, q_full, q_empty;
  cmd_t       q_in, q_head;
  back_stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= RST_CANVAS_SIDE;
      canvas_height   <= RST_CANVAS_SIDE;
      background_char <= RST_BACKGROUND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:    canvas_width    <= cfg_data[CFG_SIZE_W-1:0];
        CFG_CANVAS_HEIGHT:   canvas_height   <= cfg_data[CFG_SIZE_W-1:0];
        CFG_BACKGROUND_CHAR: background_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in use
  assign cfg_eff.width  = clamp_side(canvas_width);
  assign cfg_eff.height = clamp_side(canvas_height);
  assign cfg_eff.bg     = background_char;

  rrc_front u_front (
    .req    (req),
    .cfg    (cfg_eff),
    .q_full (q_full),
    .q_push (q_push),
    .cmd    (q_in)
  );

  rrc_cmd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .cmd_in (q_in),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  rrc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_eff),
    .q_empty (q_empty),
    .head    (q_head),
    .q_pop   (q_pop),
    .rsp     (rsp),
    .stat    (stat)
  );

  // Back end never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> !q_empty)
    else $error("command taken from empty queue");

  // No result is offered while a draw or clear is still walking
  a_walk_quiet: assert property (@(posedge clk) disable iff (rst)
    stat.walking |-> !rsp.valid)
    else $error("result offered during pixel walk");

  // A request reaching an idle, unblocked back end is taken on the next cycle
  a_prompt_start: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_empty && stat.idle && !rsp.valid) |=> stat.pop)
    else $error("idle back end did not start queued request");

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for rectangle_raster_canvas_unit: a directed script of requests
// and register writes, then random phases, checked against fixed values or the shadow model.
// Depends on rrc_pkg and the rrc_req_if / rrc_rsp_if interfaces.
`default_nettype none

module tb import rrc_pkg::*; ;

  localparam int QUIET_LIMIT    = 4 * 65536;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 16;
  localparam int NUM_PHASES     = 6;
  localparam int PHASE_ITEMS    = 13;
  localparam int WORK_BUDGET    = 120000;     // walk cycles allowed per random phase
  localparam int CLEAR_CYCLES   = MAX_SIDE * MAX_SIDE;
  localparam int HOLD_AT        = 40;         // results seen before the long stall
  localparam int HOLD_CYCLES    = 400;

  localparam logic [MODE_W-1:0]    MODE_UNUSED   = MODE_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = CFG_IDX_W'(3);
  localparam logic                 STATUS_OK     = 1'b0;
  localparam logic                 STATUS_REJECT = 1'b1;
  localparam logic [CHAR_W-1:0]    KIND_BOGUS    = 8'h51;

  localparam logic [FIELD_W-1:0] FIX_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] FIX_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam longint PIX_ONE  = longint'(1) << FRAC_BITS;
  localparam longint EDGE_SAT = (longint'(1) << (FIELD_W - 1)) - 1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  kind;
    logic [FIELD_W-1:0] left;
    logic [FIELD_W-1:0] top;
    logic [FIELD_W-1:0] width;
    logic [FIELD_W-1:0] height;
    logic [CHAR_W-1:0]  paint;
    logic [IDX_W-1:0]   col;
    logic [IDX_W-1:0]   row;
  } canvas_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_value;
    logic              status;
  } pixel_rsp_t;

  typedef enum logic {ROW_REQUEST, ROW_REGISTER} row_kind_e;

  typedef struct packed {
    row_kind_e             what;
    canvas_req_t           item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  typed;
    pixel_rsp_t            want;
  } script_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_BURSTY} stall_style_e;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rrc_req_if req_ch ();
  rrc_rsp_if rsp_ch ();

  rectangle_raster_canvas_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow of the canvas and its registers
  logic [CHAR_W-1:0]     canvas_shadow [0:MAX_SIDE*MAX_SIDE-1];
  logic [CFG_DATA_W-1:0] side_cols;
  logic [CFG_DATA_W-1:0] side_rows;
  logic [CHAR_W-1:0]     bg_byte;

  pixel_rsp_t  pending_pixels [$];
  pixel_rsp_t  oldest;
  script_row_t script [$];

  int errors;
  int results_seen;
  int quiet_cycles;
  int burst_left;
  int work_left;
  int mode_count [0:3];
  int phases_run;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Shadow model
  // ------------------------------------------------------------------
  function automatic int eff_side(input logic [CFG_DATA_W-1:0] raw);
    if (raw == 0) begin
      return 1;
    end else if (raw > MAX_SIDE) begin
      return MAX_SIDE;
    end
    return int'(raw);
  endfunction

  // Applies one request to the shadow canvas and returns the result it must give
  function automatic pixel_rsp_t predict_canvas(input canvas_req_t r);
    pixel_rsp_t res;
    longint lft, tp, wd, ht, rgt, bot, px, py;
    int cols, rows;
    logic on_edge;
    res.pixel_value = '0;
    res.status      = STATUS_OK;
    cols = eff_side(side_cols);
    rows = eff_side(side_rows);
    case (r.mode)
      MODE_DRAW: begin
        lft = longint'($signed(r.left));
        tp  = longint'($signed(r.top));
        wd  = longint'($signed(r.width));
        ht  = longint'($signed(r.height));
        if ((r.kind != KIND_FILLED && r.kind != KIND_OUTLINE) || wd <= 0 || ht <= 0) begin
          res.status = STATUS_REJECT;
        end else begin
          rgt = lft + wd;
          bot = tp + ht;
          if (rgt > EDGE_SAT) rgt = EDGE_SAT;
          if (bot > EDGE_SAT) bot = EDGE_SAT;
          for (int y = 0; y < rows; y++) begin
            py = longint'(y) * PIX_ONE;
            if (py >= tp && py <= bot) begin
              for (int x = 0; x < cols; x++) begin
                px = longint'(x) * PIX_ONE;
                if (px >= lft && px <= rgt) begin
                  // outline keeps pixels less than one unit from any edge
                  on_edge = (rgt - px) < PIX_ONE || (bot - py) < PIX_ONE ||
                            (px - lft) < PIX_ONE || (py - tp) < PIX_ONE;
                  if (r.kind == KIND_FILLED || on_edge) begin
                    canvas_shadow[y*MAX_SIDE + x] = r.paint;
                  end
                end
              end
            end
          end
        end
      end
      MODE_READ: begin
        if (int'(r.col) >= cols || int'(r.row) >= rows) begin
          res.status = STATUS_REJECT;
        end else begin
          res.pixel_value = canvas_shadow[int'(r.row)*MAX_SIDE + int'(r.col)];
        end
      end
      MODE_CLEAR: begin
        // the whole store, not just the part in use
        for (int i = 0; i < MAX_SIDE*MAX_SIDE; i++) canvas_shadow[i] = bg_byte;
      end
      default: begin
        res.status = STATUS_REJECT;
      end
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Request builders and script rows
  // ------------------------------------------------------------------
  function automatic canvas_req_t draw_item(input logic [CHAR_W-1:0] kind,
                                            input logic [FIELD_W-1:0] l, t, w, h,
                                            input logic [CHAR_W-1:0] paint);
    canvas_req_t it;
    it = '0;
    it.mode   = MODE_DRAW;
    it.kind   = kind;
    it.left   = l;
    it.top    = t;
    it.width  = w;
    it.height = h;
    it.paint  = paint;
    return it;
  endfunction

  function automatic canvas_req_t read_item(input int c, input int r);
    canvas_req_t it;
    it = '0;
    it.mode = MODE_READ;
    it.col  = IDX_W'(c);
    it.row  = IDX_W'(r);
    return it;
  endfunction

  function automatic canvas_req_t plain_item(input logic [MODE_W-1:0] m);
    canvas_req_t it;
    it = '0;
    it.mode = m;
    return it;
  endfunction

  function automatic pixel_rsp_t pix(input logic [CHAR_W-1:0] v, input logic st);
    pixel_rsp_t p;
    p.pixel_value = v;
    p.status      = st;
    return p;
  endfunction

  function automatic script_row_t do_req(input canvas_req_t it);
    script_row_t s;
    s = '0;
    s.what = ROW_REQUEST;
    s.item = it;
    return s;
  endfunction

  function automatic script_row_t do_chk(input canvas_req_t it, input pixel_rsp_t want);
    script_row_t s;
    s = do_req(it);
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic script_row_t do_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
    script_row_t s;
    s = '0;
    s.what    = ROW_REGISTER;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  // Random request: every field starts as noise, then the category shapes it
  function automatic canvas_req_t next_random_item();
    canvas_req_t it;
    int pick, cols, rows, area, base;
    cols = eff_side(side_cols);
    rows = eff_side(side_rows);
    area = cols * rows;
    it.mode   = MODE_W'($urandom);
    it.kind   = CHAR_W'($urandom);
    it.left   = FIELD_W'($urandom);
    it.top    = FIELD_W'($urandom);
    it.width  = FIELD_W'($urandom);
    it.height = FIELD_W'($urandom);
    it.paint  = CHAR_W'($urandom);
    it.col    = IDX_W'($urandom);
    it.row    = IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick >= 95 && work_left >= CLEAR_CYCLES) begin
      it.mode = MODE_CLEAR;
      work_left -= CLEAR_CYCLES;
    end else if (pick >= 90) begin
      it.mode = MODE_UNUSED;
    end else if (pick >= 80) begin
      // broken draw: bad kind, or a side that is zero or negative
      it.mode = MODE_DRAW;
      case ($urandom_range(0, 2))
        0: if (it.kind == KIND_FILLED || it.kind == KIND_OUTLINE) it.kind = KIND_BOGUS;
        1: begin
          it.kind  = KIND_FILLED;
          it.width = FIELD_W'(-int'($urandom_range(0, 524288)));
        end
        default: begin
          it.kind   = KIND_OUTLINE;
          it.height = FIELD_W'(-int'($urandom_range(0, 524288)));
        end
      endcase
    end else if (pick < 45 && work_left >= area) begin
      it.mode = MODE_DRAW;
      it.kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
      work_left -= area;
      // mostly near the canvas, with a fraction, sometimes left as noise
      if ($urandom_range(0, 6) != 0) begin
        base    = int'($urandom_range(0, cols + 3)) - 2;
        it.left = FIELD_W'(base * 256 + int'($urandom_range(0, 255)) - 128);
        base    = int'($urandom_range(0, rows + 3)) - 2;
        it.top  = FIELD_W'(base * 256 + int'($urandom_range(0, 255)) - 128);
      end
      if ($urandom_range(0, 9) == 0) begin
        it.width[FIELD_W-1]  = 1'b0;
        it.height[FIELD_W-1] = 1'b0;
        if (it.width == 0) it.width = FIELD_W'(1);
        if (it.height == 0) it.height = FIELD_W'(1);
      end else begin
        it.width  = FIELD_W'($urandom_range(1, (cols + 1) * 256));
        it.height = FIELD_W'($urandom_range(1, (rows + 1) * 256));
      end
    end else begin
      it.mode = MODE_READ;
      if ($urandom_range(0, 9) != 0) begin
        it.col = IDX_W'($urandom_range(0, cols - 1));
        it.row = IDX_W'($urandom_range(0, rows - 1));
      end
    end
    return it;
  endfunction

  // ------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------
  // Offers one request in bursts with random gaps; on accept, records the expected result
  task automatic offer(input canvas_req_t it, input logic typed, input pixel_rsp_t want);
    int gap;
    pixel_rsp_t got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.mode        = it.mode;
    req_ch.rect_kind   = it.kind;
    req_ch.rect_left   = it.left;
    req_ch.rect_top    = it.top;
    req_ch.rect_width  = it.width;
    req_ch.rect_height = it.height;
    req_ch.paint_char  = it.paint;
    req_ch.pixel_col   = it.col;
    req_ch.pixel_row   = it.row;
    req_ch.valid       = 1'b1;
    while (1) begin
      @(posedge clk);
      if (req_ch.ready) break;
    end
    got = predict_canvas(it);
    pending_pixels.push_back(typed ? want : got);
    mode_count[it.mode]++;
  endtask

  // Register write once the block has drained
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    req_ch.valid = 1'b0;
    burst_left   = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      CFG_CANVAS_WIDTH:    side_cols = val;
      CFG_CANVAS_HEIGHT:   side_rows = val;
      CFG_BACKGROUND_CHAR: bg_byte   = val[CHAR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Result side: stall patterns plus one long hold-off
  // ------------------------------------------------------------------
  initial begin
    stall_style_e style;
    int span;
    logic held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      style = stall_style_e'($urandom_range(0, 3));
      span  = $urandom_range(20, 200);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (!held && results_seen >= HOLD_AT) begin
          held = 1'b1;
          rsp_ch.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (style)
          STALL_NONE:   rsp_ch.ready = 1'b1;
          STALL_COIN:   rsp_ch.ready = ($urandom_range(0, 2) != 0);
          STALL_THIRD:  rsp_ch.ready = (k % 3 == 0);
          STALL_BURSTY: rsp_ch.ready = ((k / 7) % 2 == 0);
          default:      rsp_ch.ready = 1'b1;
        endcase
      end
    end
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("tb: result %0d: %s got %0h, want %0h", results_seen, what, got, want);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected result, pixel_value", rsp_ch.pixel_value, 0);
      end else begin
        oldest = pending_pixels.pop_front();
        if (rsp_ch.pixel_value !== oldest.pixel_value)
          report("pixel_value", rsp_ch.pixel_value, oldest.pixel_value);
        if (rsp_ch.status !== oldest.status)
          report("status", rsp_ch.status, oldest.status);
      end
      results_seen++;
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb: no handshake for %0d cycles, %0d results outstanding",
             quiet_cycles, pending_pixels.size());
    $display("tb: done, errors");
    $finish;
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] pc, pr;
    logic [CHAR_W-1:0] pb;
    errors       = 0;
    results_seen = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    phases_run   = 0;
    for (int m = 0; m < 4; m++) mode_count[m] = 0;
    side_cols = RST_CANVAS_SIDE;
    side_rows = RST_CANVAS_SIDE;
    bg_byte   = RST_BACKGROUND;
    for (int i = 0; i < MAX_SIDE*MAX_SIDE; i++) canvas_shadow[i] = '0;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = '0;
    req_ch.rect_kind   = '0;
    req_ch.rect_left   = '0;
    req_ch.rect_top    = '0;
    req_ch.rect_width  = '0;
    req_ch.rect_height = '0;
    req_ch.paint_char  = '0;
    req_ch.pixel_col   = '0;
    req_ch.pixel_row   = '0;

    // Directed script; the first request clears, so no read sees an unwritten pixel
    script.push_back(do_chk(plain_item(MODE_CLEAR), pix(8'h00, STATUS_OK)));
    script.push_back(do_chk(read_item(0, 0), pix(RST_BACKGROUND, STATUS_OK)));
    script.push_back(do_chk(read_item(255, 255), pix(RST_BACKGROUND, STATUS_OK)));
    script.push_back(do_chk(plain_item(MODE_UNUSED), pix(8'h00, STATUS_REJECT)));
    script.push_back(do_cfg(CFG_CANVAS_WIDTH, 9'd16));
    script.push_back(do_cfg(CFG_CANVAS_HEIGHT, 9'd12));
    script.push_back(do_cfg(CFG_BACKGROUND_CHAR, 9'h0FF));
    script.push_back(do_cfg(CFG_UNUSED, 9'h1FF));
    script.push_back(do_chk(plain_item(MODE_CLEAR), pix(8'h00, STATUS_OK)));
    script.push_back(do_chk(read_item(15, 11), pix(8'hFF, STATUS_OK)));
    // reads past the size in use
    script.push_back(do_chk(read_item(16, 0), pix(8'h00, STATUS_REJECT)));
    script.push_back(do_chk(read_item(0, 12), pix(8'h00, STATUS_REJECT)));
    // bad kind, zero width, most negative height
    script.push_back(do_chk(draw_item(KIND_BOGUS, '0, '0, 20'h400, 20'h400, "x"),
                            pix(8'h00, STATUS_REJECT)));
    script.push_back(do_chk(draw_item(KIND_FILLED, '0, '0, '0, 20'h100, "x"),
                            pix(8'h00, STATUS_REJECT)));
    script.push_back(do_chk(draw_item(KIND_OUTLINE, '0, '0, 20'h100, FIX_MIN, "x"),
                            pix(8'h00, STATUS_REJECT)));
    // extreme corners: edges stay left of the canvas, or saturate right and bottom
    script.push_back(do_req(draw_item(KIND_FILLED, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MAX, 8'h00)));
    script.push_back(do_req(draw_item(KIND_FILLED, 20'h100, 20'h080, FIX_MAX, 20'h380, "A")));
    script.push_back(do_req(draw_item(KIND_OUTLINE, 20'h180, 20'h180, 20'h900, 20'h600, "#")));
    script.push_back(do_req(draw_item(KIND_OUTLINE, FIX_MAX, FIX_MAX, 20'h001, 20'h001,
                                      8'h00)));
    script.push_back(do_req(read_item(1, 1)));
    script.push_back(do_req(read_item(2, 2)));
    script.push_back(do_req(read_item(3, 3)));
    script.push_back(do_req(read_item(12, 5)));
    script.push_back(do_req(read_item(15, 0)));
    // size registers at zero act as a single pixel
    script.push_back(do_cfg(CFG_CANVAS_WIDTH, 9'd0));
    script.push_back(do_cfg(CFG_CANVAS_HEIGHT, 9'd0));
    script.push_back(do_req(draw_item(KIND_FILLED, '0, '0, 20'h100, 20'h100, 8'hAA)));
    script.push_back(do_chk(read_item(0, 0), pix(8'hAA, STATUS_OK)));
    script.push_back(do_chk(read_item(1, 0), pix(8'h00, STATUS_REJECT)));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      if (script[i].what == ROW_REGISTER) begin
        set_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer(script[i].item, script[i].typed, script[i].want);
      end
    end

    // Random phases: oversized, one column, one row, then small random canvases
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin pc = 9'd511; pr = 9'd300; pb = 8'h00; end
        1: begin pc = 9'd1;   pr = 9'd256; pb = 8'hFF; end
        2: begin pc = 9'd256; pr = 9'd1;   pb = CHAR_W'($urandom); end
        default: begin
          pc = CFG_DATA_W'($urandom_range(2, 24));
          pr = CFG_DATA_W'($urandom_range(2, 24));
          pb = CHAR_W'($urandom);
        end
      endcase
      set_reg(CFG_CANVAS_WIDTH, pc);
      set_reg(CFG_CANVAS_HEIGHT, pr);
      set_reg(CFG_BACKGROUND_CHAR, {1'b0, pb});
      work_left = WORK_BUDGET;
      for (int n = 0; n < PHASE_ITEMS; n++) offer(next_random_item(), 1'b0, pix(8'h00, STATUS_OK));
      phases_run++;
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d draws, %0d reads, %0d clears, %0d unused-mode requests checked",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("tb: %0d results over %0d random canvas settings plus the directed script",
             results_seen, phases_run);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
